/* hdl/mbct_pkg.sv */
package mbct_pkg;

    // Table size used when the top level is not given one.
    localparam int TABLE_SLOTS_DEF = 512;

    // Depth of the queue between the front and the engine.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // The broadcast address is never stored or counted.
    localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

    // Result status codes.
    localparam logic [2:0] STATUS_NEW      = 3'd0;
    localparam logic [2:0] STATUS_ACC      = 3'd1;
    localparam logic [2:0] STATUS_BCAST    = 3'd2;
    localparam logic [2:0] STATUS_FULL     = 3'd3;
    localparam logic [2:0] STATUS_READ_OK  = 3'd4;
    localparam logic [2:0] STATUS_READ_BAD = 3'd5;

    // Request type codes.
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Input word.
    typedef struct packed {
        logic        req_type;
        logic [47:0] mac_address;
        logic [15:0] byte_count;
        logic [8:0]  entry_index;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [2:0]  status;
        logic [8:0]  slot_index;
        logic [47:0] mac_out;
        logic [31:0] total_bytes;
        logic [9:0]  entries_used;
    } t_out_word;

    // Class that the front assigns to each word.
    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_BCAST,
        KIND_READ
    } t_kind;

    // One queue entry between front and engine.
    typedef struct packed {
        t_kind    kind;
        t_in_word word;
    } t_queue_entry;

    // One table entry.
    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] total;
    } t_entry;

    // Engine states.
    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_SCAN,
        ENG_ACC,
        ENG_INS,
        ENG_RD,
        ENG_EMIT
    } t_eng_state;

endpackage

/* hdl/mbct_front.sv */
module mbct_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  mbct_pkg::t_in_word    i_in_word,
    output logic                  o_q_valid,
    output mbct_pkg::t_queue_entry o_q_entry,
    input  logic                  i_q_pop
);

    mbct_pkg::t_queue_entry               r_q [mbct_pkg::QUEUE_DEPTH];
    logic [mbct_pkg::QUEUE_PTR_W-1:0]     r_wr_ptr;
    logic [mbct_pkg::QUEUE_PTR_W-1:0]     r_rd_ptr;
    logic [mbct_pkg::QUEUE_CNT_W-1:0]     r_count;
    logic [mbct_pkg::QUEUE_PTR_W-1:0]     n_wr_ptr;
    logic [mbct_pkg::QUEUE_PTR_W-1:0]     n_rd_ptr;
    logic [mbct_pkg::QUEUE_CNT_W-1:0]     n_count;
    logic                                 push;
    logic                                 pop;
    mbct_pkg::t_queue_entry               in_entry;

    // Classify the incoming word.
    always_comb begin
        in_entry.word = i_in_word;
        if (i_in_word.req_type == mbct_pkg::REQ_READ) begin
            in_entry.kind = mbct_pkg::KIND_READ;
        end else if (i_in_word.mac_address == mbct_pkg::BCAST_MAC) begin
            in_entry.kind = mbct_pkg::KIND_BCAST;
        end else begin
            in_entry.kind = mbct_pkg::KIND_ADD;
        end
    end

    // Queue handshake.
    assign o_in_stall = (r_count == mbct_pkg::QUEUE_CNT_W'(mbct_pkg::QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_entry  = r_q[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            if (r_wr_ptr == mbct_pkg::QUEUE_PTR_W'(mbct_pkg::QUEUE_DEPTH - 1)) begin
                n_wr_ptr = '0;
            end else begin
                n_wr_ptr = r_wr_ptr + 1'b1;
            end
        end
        if (pop) begin
            if (r_rd_ptr == mbct_pkg::QUEUE_PTR_W'(mbct_pkg::QUEUE_DEPTH - 1)) begin
                n_rd_ptr = '0;
            end else begin
                n_rd_ptr = r_rd_ptr + 1'b1;
            end
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_entry;
        end
    end

endmodule

/* hdl/mbct_engine.sv */
module mbct_engine #(
    parameter int TABLE_SLOTS = mbct_pkg::TABLE_SLOTS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  mbct_pkg::t_queue_entry i_q_entry,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output mbct_pkg::t_out_word    o_out_word
);

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);

    // Table memory and its registered read port.
    mbct_pkg::t_entry       r_mem [TABLE_SLOTS];
    mbct_pkg::t_entry       r_rd_data;

    mbct_pkg::t_eng_state   r_state;
    mbct_pkg::t_eng_state   n_state;
    mbct_pkg::t_queue_entry r_item;
    logic [CW-1:0]          r_used;
    logic [CW-1:0]          n_used;
    logic [CW-1:0]          r_scan_addr;
    logic [CW-1:0]          n_scan_addr;
    logic                   r_cmp_vld;
    logic                   n_cmp_vld;
    logic [IW-1:0]          r_cmp_addr;
    logic [IW-1:0]          n_cmp_addr;
    logic                   r_out_vld;
    mbct_pkg::t_out_word    r_out;

    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    mbct_pkg::t_entry       wr_data;
    logic                   emit;
    mbct_pkg::t_out_word    emit_word;
    logic                   out_free;
    logic                   hit;
    logic                   scan_done;
    logic                   q_idx_ok;
    logic [31:0]            q_idx_w;
    logic [31:0]            used_w;
    logic [31:0]            used_next_w;
    logic [31:0]            cmp_addr_w;
    logic [32:0]            sum;
    logic [31:0]            sat_sum;

    // Widened views for index compares and output truncation.
    assign q_idx_w     = 32'(i_q_entry.word.entry_index);
    assign used_w      = 32'(r_used);
    assign used_next_w = used_w + 32'd1;
    assign cmp_addr_w  = 32'(r_cmp_addr);
    assign q_idx_ok    = (q_idx_w < used_w) && (q_idx_w < 32'(TABLE_SLOTS));

    // Scan compare on the entry read in the previous cycle.
    assign hit       = r_cmp_vld && (r_rd_data.mac == r_item.word.mac_address);
    assign scan_done = !r_cmp_vld && !(r_scan_addr < r_used);

    // Saturating accumulate.
    assign sum     = {1'b0, r_rd_data.total} + 33'(r_item.word.byte_count);
    assign sat_sum = sum[32] ? '1 : sum[31:0];

    assign out_free = !r_out_vld || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mbct_pkg::ENG_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_entry.kind)
                        mbct_pkg::KIND_READ: begin
                            n_state = q_idx_ok ? mbct_pkg::ENG_RD : mbct_pkg::ENG_EMIT;
                        end
                        mbct_pkg::KIND_ADD: begin
                            n_state = (r_used == '0) ? mbct_pkg::ENG_INS : mbct_pkg::ENG_SCAN;
                        end
                        default: begin
                            n_state = mbct_pkg::ENG_EMIT;
                        end
                    endcase
                end
            end
            mbct_pkg::ENG_SCAN: begin
                if (hit) begin
                    n_state = mbct_pkg::ENG_ACC;
                end else if (scan_done) begin
                    n_state = mbct_pkg::ENG_INS;
                end
            end
            mbct_pkg::ENG_ACC,
            mbct_pkg::ENG_INS,
            mbct_pkg::ENG_RD,
            mbct_pkg::ENG_EMIT: begin
                if (out_free) begin
                    n_state = mbct_pkg::ENG_IDLE;
                end
            end
            default: begin
                n_state = mbct_pkg::ENG_IDLE;
            end
        endcase
    end

    // State outputs: memory access, scan control and result building.
    always_comb begin
        o_q_pop     = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        emit        = 1'b0;
        emit_word   = '0;
        n_used      = r_used;
        n_scan_addr = r_scan_addr;
        n_cmp_vld   = 1'b0;
        n_cmp_addr  = r_cmp_addr;
        case (r_state)
            mbct_pkg::ENG_IDLE: begin
                o_q_pop = i_q_valid;
                if (i_q_valid) begin
                    if (i_q_entry.kind == mbct_pkg::KIND_READ && q_idx_ok) begin
                        rd_en   = 1'b1;
                        rd_addr = q_idx_w[IW-1:0];
                    end else if (i_q_entry.kind == mbct_pkg::KIND_ADD && r_used != '0) begin
                        // Start the scan at slot zero.
                        rd_en       = 1'b1;
                        rd_addr     = '0;
                        n_scan_addr = CW'(1);
                        n_cmp_vld   = 1'b1;
                        n_cmp_addr  = '0;
                    end
                end
            end
            mbct_pkg::ENG_SCAN: begin
                // One slot issued per cycle until a hit or the end of the used slots.
                if (!hit && (r_scan_addr < r_used)) begin
                    rd_en       = 1'b1;
                    rd_addr     = r_scan_addr[IW-1:0];
                    n_scan_addr = r_scan_addr + 1'b1;
                    n_cmp_vld   = 1'b1;
                    n_cmp_addr  = r_scan_addr[IW-1:0];
                end
            end
            mbct_pkg::ENG_ACC: begin
                if (out_free) begin
                    wr_en                  = 1'b1;
                    wr_addr                = r_cmp_addr;
                    wr_data.mac            = r_item.word.mac_address;
                    wr_data.total          = sat_sum;
                    emit                   = 1'b1;
                    emit_word.status       = mbct_pkg::STATUS_ACC;
                    emit_word.slot_index   = cmp_addr_w[8:0];
                    emit_word.mac_out      = r_item.word.mac_address;
                    emit_word.total_bytes  = sat_sum;
                    emit_word.entries_used = used_w[9:0];
                end
            end
            mbct_pkg::ENG_INS: begin
                if (out_free) begin
                    emit                  = 1'b1;
                    emit_word.mac_out     = r_item.word.mac_address;
                    if (r_used != SLOTS_C) begin
                        // Take the next free slot.
                        wr_en                  = 1'b1;
                        wr_addr                = r_used[IW-1:0];
                        wr_data.mac            = r_item.word.mac_address;
                        wr_data.total          = 32'(r_item.word.byte_count);
                        n_used                 = r_used + 1'b1;
                        emit_word.status       = mbct_pkg::STATUS_NEW;
                        emit_word.slot_index   = used_w[8:0];
                        emit_word.total_bytes  = 32'(r_item.word.byte_count);
                        emit_word.entries_used = used_next_w[9:0];
                    end else begin
                        emit_word.status       = mbct_pkg::STATUS_FULL;
                        emit_word.entries_used = used_w[9:0];
                    end
                end
            end
            mbct_pkg::ENG_RD: begin
                if (out_free) begin
                    emit                   = 1'b1;
                    emit_word.status       = mbct_pkg::STATUS_READ_OK;
                    emit_word.slot_index   = r_item.word.entry_index;
                    emit_word.mac_out      = r_rd_data.mac;
                    emit_word.total_bytes  = r_rd_data.total;
                    emit_word.entries_used = used_w[9:0];
                end
            end
            mbct_pkg::ENG_EMIT: begin
                if (out_free) begin
                    emit                   = 1'b1;
                    emit_word.entries_used = used_w[9:0];
                    if (r_item.kind == mbct_pkg::KIND_READ) begin
                        emit_word.status     = mbct_pkg::STATUS_READ_BAD;
                        emit_word.slot_index = r_item.word.entry_index;
                    end else begin
                        emit_word.status  = mbct_pkg::STATUS_BCAST;
                        emit_word.mac_out = r_item.word.mac_address;
                    end
                end
            end
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mbct_pkg::ENG_IDLE;
            r_used    <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_cmp_vld <= n_cmp_vld;
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (out_free) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_entry;
        end
        r_scan_addr <= n_scan_addr;
        r_cmp_addr  <= n_cmp_addr;
        if (emit) begin
            r_out <= emit_word;
        end
    end

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    // The used count never passes the table size.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= SLOTS_C)
        else $error("used count beyond table size");

    // Writes land only on a used slot or on the next free one.
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (32'(wr_addr) <= used_w))
        else $error("table write outside used range");

    // A pending compare exists only while scanning.
    a_cmp_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_state == mbct_pkg::ENG_SCAN))
        else $error("compare pending outside scan");

    // A new-entry result grows the used count by exactly one.
    a_new_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (emit_word.status == mbct_pkg::STATUS_NEW))
            |=> (r_used == ($past(r_used) + CW'(1))))
        else $error("new entry without used count step");
`endif

endmodule

/* hdl/mac_byte_count_table.sv */
// Reads and broadcasts pass from the queue to the result register; an add first scans the
// used slots until a hit and accumulates there, or takes the next free slot, if any, on a miss.
// The table memory is scanned one slot per cycle through its single registered read port.
// The engine handles one word at a time; a two-word queue takes new words while it works.
// Reset: synchronous, active low; clears the used count and control state, not the table.
module mac_byte_count_table #(
    parameter int TABLE_SLOTS = mbct_pkg::TABLE_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mbct_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mbct_pkg::t_out_word o_out_word
);

    logic                   q_valid;
    logic                   q_pop;
    mbct_pkg::t_queue_entry q_entry;

    // Front: accept, classify and queue words.
    mbct_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_q_valid  (q_valid),
        .o_q_entry  (q_entry),
        .i_q_pop    (q_pop)
    );

    // Engine: table lookup, update and result register.
    mbct_engine #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
